### hw/rtl/fec_pkg.sv
// fec_pkg: types and fixed constants shared by the free extent coalescer
// payload structs for the free and result channels, status codes
// no dependencies
`timescale 1ns / 1ps

package fec_pkg;

    localparam int BASE_W   = 32;
    localparam int SIZE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int MERGES_W = 2;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 32;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd2;

    typedef struct packed {
        logic [BASE_W-1:0] free_base;
        logic [SIZE_W-1:0] free_size;
    } free_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MERGES_W-1:0] merges_done;
        logic [COUNT_W-1:0]  entry_count;
        logic [TOTAL_W-1:0]  merge_total;
    } result_item_t;

endpackage

### hw/rtl/free_extent_coalescer.sv
// free_extent_coalescer: address-ordered free extent table with neighbor coalescing
// one table memory, one shared compare/add unit under a small sequencer
// depends on fec_pkg
//
// channel   dir  handshake                 payload
// cfg       in   cfg_we                    cfg_wdata (check_overlap)
// free      in   free_valid / free_stall   free_item   (fec_pkg::free_item_t)
// result    out  result_valid / result_stall  result_item (fec_pkg::result_item_t)
//
// a free makes two passes over the N stored extents when the overlap check is on or
// the table is full (check pass, then rewrite pass), else only the rewrite pass.
// a rejected free ends right after the check pass; an empty table skips both passes.
// each entry is read from the table in one state and evaluated in the next.
// reset clears the entry count, the merge total and sets check_overlap; table contents stay.
// free_stall is high from a transfer until its result is loaded into the output register;
// a new free is taken while that result still waits on result_stall.
`timescale 1ns / 1ps

module free_extent_coalescer #(
    parameter int MAX_EXTENTS = 64,
    parameter int ADDR_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 free_valid,
    output logic                 free_stall,
    input  fec_pkg::free_item_t  free_item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output fec_pkg::result_item_t result_item
);

    localparam int LEN_BITS  = ADDR_BITS + 1;
    localparam int SUM_BITS  = ADDR_BITS + 2;
    localparam int WIDE_BITS = (LEN_BITS > fec_pkg::SIZE_W) ? LEN_BITS : fec_pkg::SIZE_W;
    localparam int MEM_W     = ADDR_BITS + LEN_BITS;
    localparam int CW        = $clog2(MAX_EXTENTS + 1);
    localparam int IW        = $clog2(MAX_EXTENTS);

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
    localparam logic [CW-1:0]       CNT_MAX = CW'(MAX_EXTENTS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_P1_RD   = 3'd1;
    localparam logic [2:0] S_P1_EV   = 3'd2;
    localparam logic [2:0] S_P1_END  = 3'd3;
    localparam logic [2:0] S_P2_RD   = 3'd4;
    localparam logic [2:0] S_P2_EV   = 3'd5;
    localparam logic [2:0] S_P2_TAIL = 3'd6;
    localparam logic [2:0] S_FIN     = 3'd7;

    localparam logic [1:0] MODE_SCAN  = 2'd0;
    localparam logic [1:0] MODE_SHIFT = 2'd1;
    localparam logic [1:0] MODE_COPY  = 2'd2;

    // table memory
    logic [MEM_W-1:0] ext_mem [MAX_EXTENTS];
    logic [MEM_W-1:0] mem_q;
    logic             mem_we;
    logic             mem_re;
    logic [IW-1:0]    mem_waddr;
    logic [IW-1:0]    mem_raddr;
    logic [MEM_W-1:0] mem_wdata;

    // sequencer state
    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     mode_reg, mode_next;
    logic [CW-1:0]                  r_reg, r_next;
    logic [CW-1:0]                  w_reg, w_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [CW-1:0]                  merges_reg, merges_next;
    logic [fec_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic                           check_reg;
    logic                           overlap_reg, overlap_next;
    logic [fec_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           result_valid_reg, result_valid_next;
    fec_pkg::result_item_t          result_item_reg, result_item_next;

    // payload registers
    logic [ADDR_BITS-1:0] fb_reg, fb_next;
    logic [LEN_BITS-1:0]  fl_reg, fl_next;
    logic [ADDR_BITS-1:0] ab_reg, ab_next;
    logic [LEN_BITS-1:0]  al_reg, al_next;
    logic [MEM_W-1:0]     hold_reg, hold_next;

    // input conversion
    logic [ADDR_BITS-1:0] fb_in;
    logic [WIDE_BITS-1:0] fs_wide;
    logic [LEN_BITS-1:0]  fl_in;

    // shared compare / add unit
    logic [ADDR_BITS-1:0] ent_base;
    logic [LEN_BITS-1:0]  ent_len;
    logic [SUM_BITS-1:0]  sum_right;
    logic [SUM_BITS-1:0]  sum_ent;
    logic [SUM_BITS-1:0]  sum_len;
    logic [SUM_BITS-1:0]  sum_free;
    logic                 hit_right;
    logic                 hit_left;
    logic                 hit_below;
    logic                 hit_overlap;
    logic [LEN_BITS-1:0]  len_merged;
    logic [CW-1:0]        r_inc;
    logic [CW-1:0]        w_inc;
    logic [CW-1:0]        merges_inc;
    logic [fec_pkg::TOTAL_W-1:0] total_inc;

    assign fb_in   = ADDR_BITS'(free_item.free_base);
    assign fs_wide = WIDE_BITS'(free_item.free_size);
    assign fl_in   = (fs_wide > WIDE_BITS'(LEN_MAX)) ? LEN_MAX : LEN_BITS'(fs_wide);

    assign ent_base = mem_q[MEM_W-1:LEN_BITS];
    assign ent_len  = mem_q[LEN_BITS-1:0];

    // exact end addresses, no wrap
    assign sum_right = SUM_BITS'(ab_reg) + SUM_BITS'(al_reg);
    assign sum_ent   = SUM_BITS'(ent_base) + SUM_BITS'(ent_len);
    assign sum_len   = SUM_BITS'(al_reg) + SUM_BITS'(ent_len);
    assign sum_free  = SUM_BITS'(fb_reg) + SUM_BITS'(fl_reg);

    assign hit_right   = (sum_right == SUM_BITS'(ent_base));
    assign hit_left    = (sum_ent == SUM_BITS'(ab_reg));
    assign hit_below   = (ab_reg < ent_base);
    assign len_merged  = sum_len[LEN_BITS] ? LEN_MAX : sum_len[LEN_BITS-1:0];
    assign hit_overlap = (fl_reg != '0) && (ent_len != '0)
                         && (SUM_BITS'(fb_reg) < sum_ent)
                         && (SUM_BITS'(ent_base) < sum_free);

    assign r_inc      = r_reg + CW'(1);
    assign w_inc      = w_reg + CW'(1);
    assign merges_inc = merges_reg + CW'(1);
    assign total_inc  = (total_reg == '1) ? total_reg : total_reg + fec_pkg::TOTAL_W'(1);

    assign free_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        r_next            = r_reg;
        w_next            = w_reg;
        cnt_next          = cnt_reg;
        merges_next       = merges_reg;
        total_next        = total_reg;
        overlap_next      = overlap_reg;
        status_next       = status_reg;
        fb_next           = fb_reg;
        fl_next           = fl_reg;
        ab_next           = ab_reg;
        al_next           = al_reg;
        hold_next         = hold_reg;
        result_item_next  = result_item_reg;
        result_valid_next = result_valid_reg && result_stall;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = w_reg[IW-1:0];
        mem_raddr         = r_reg[IW-1:0];
        mem_wdata         = mem_q;

        case (state_reg)
            S_IDLE:
            begin
                if (free_valid)
                begin
                    fb_next      = fb_in;
                    fl_next      = fl_in;
                    ab_next      = fb_in;
                    al_next      = fl_in;
                    r_next       = '0;
                    w_next       = '0;
                    merges_next  = '0;
                    mode_next    = MODE_SCAN;
                    overlap_next = 1'b0;
                    status_next  = fec_pkg::STATUS_OK;
                    if (cnt_reg != '0 && (check_reg || cnt_reg == CNT_MAX))
                        state_next = S_P1_RD;
                    else if (cnt_reg == '0)
                        state_next = S_P2_TAIL;
                    else
                        state_next = S_P2_RD;
                end
            end

            S_P1_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_P1_EV;
            end

            // check pass: overlap over the whole table when enabled, merge count for the full check
            S_P1_EV:
            begin
                if (check_reg && hit_overlap)
                    overlap_next = 1'b1;
                if (mode_reg == MODE_SCAN)
                begin
                    if (hit_right)
                    begin
                        merges_next = merges_inc;
                        mode_next   = MODE_COPY;
                    end
                    else if (hit_left)
                    begin
                        ab_next     = ent_base;
                        al_next     = len_merged;
                        merges_next = merges_inc;
                    end
                    else if (hit_below)
                    begin
                        mode_next = MODE_COPY;
                    end
                end
                r_next     = r_inc;
                state_next = (r_inc == cnt_reg) ? S_P1_END : S_P1_RD;
            end

            S_P1_END:
            begin
                if (overlap_reg)
                begin
                    status_next = fec_pkg::STATUS_OVERLAP;
                    state_next  = S_FIN;
                end
                else if (merges_reg == '0 && cnt_reg == CNT_MAX)
                begin
                    status_next = fec_pkg::STATUS_FULL;
                    state_next  = S_FIN;
                end
                else
                begin
                    ab_next     = fb_reg;
                    al_next     = fl_reg;
                    merges_next = '0;
                    r_next      = '0;
                    w_next      = '0;
                    mode_next   = MODE_SCAN;
                    state_next  = S_P2_RD;
                end
            end

            S_P2_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_P2_EV;
            end

            // rewrite pass: compacts left merges, merges into a right neighbour, shifts up after an insertion
            S_P2_EV:
            begin
                case (mode_reg)
                    MODE_SCAN:
                    begin
                        if (hit_right)
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = {ab_reg, len_merged};
                            w_next      = w_inc;
                            merges_next = merges_inc;
                            total_next  = total_inc;
                            mode_next   = MODE_COPY;
                        end
                        else if (hit_left)
                        begin
                            ab_next     = ent_base;
                            al_next     = len_merged;
                            merges_next = merges_inc;
                            total_next  = total_inc;
                        end
                        else if (hit_below)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {ab_reg, al_reg};
                            w_next    = w_inc;
                            hold_next = mem_q;
                            mode_next = MODE_SHIFT;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            w_next = w_inc;
                        end
                    end
                    MODE_SHIFT:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = hold_reg;
                        w_next    = w_inc;
                        hold_next = mem_q;
                    end
                    default:
                    begin
                        mem_we = 1'b1;
                        w_next = w_inc;
                    end
                endcase
                r_next     = r_inc;
                state_next = (r_inc == cnt_reg) ? S_P2_TAIL : S_P2_RD;
            end

            S_P2_TAIL:
            begin
                if (mode_reg == MODE_SCAN)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {ab_reg, al_reg};
                    w_next    = w_inc;
                end
                else if (mode_reg == MODE_SHIFT)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = hold_reg;
                    w_next    = w_inc;
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next            = 1'b1;
                    result_item_next.status      = status_reg;
                    result_item_next.merge_total = total_reg;
                    if (status_reg == fec_pkg::STATUS_OK)
                    begin
                        cnt_next                     = w_reg;
                        result_item_next.merges_done = fec_pkg::MERGES_W'(merges_reg);
                        result_item_next.entry_count = fec_pkg::COUNT_W'(w_reg);
                    end
                    else
                    begin
                        result_item_next.merges_done = '0;
                        result_item_next.entry_count = fec_pkg::COUNT_W'(cnt_reg);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ext_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= ext_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mode_reg         <= MODE_SCAN;
            r_reg            <= '0;
            w_reg            <= '0;
            cnt_reg          <= '0;
            merges_reg       <= '0;
            total_reg        <= '0;
            check_reg        <= 1'b1;
            overlap_reg      <= 1'b0;
            status_reg       <= fec_pkg::STATUS_OK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            r_reg            <= r_next;
            w_reg            <= w_next;
            cnt_reg          <= cnt_next;
            merges_reg       <= merges_next;
            total_reg        <= total_next;
            overlap_reg      <= overlap_next;
            status_reg       <= status_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
                check_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        fb_reg          <= fb_next;
        fl_reg          <= fl_next;
        ab_reg          <= ab_next;
        al_reg          <= al_next;
        hold_reg        <= hold_next;
        result_item_reg <= result_item_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("stored extent count above table depth");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_reg >= $past(total_reg))
        else $error("merge total went down");

    // rewrite must never land on an entry not yet read
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P2_EV) |-> (w_reg <= r_reg))
        else $error("table rewrite overtook the read pointer");

    a_count_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FIN) |=> (cnt_reg == $past(cnt_reg)))
        else $error("entry count changed outside the finish step");

endmodule
